// File: hdl/nearest_palette_color_assert.svh
// ----------------------------------------------------------------------------
// nearest_palette_color assertion macros
// Shared property forms for the checker of the nearest palette color block.
// ----------------------------------------------------------------------------
`ifndef NEAREST_PALETTE_COLOR_ASSERT_SVH
`define NEAREST_PALETTE_COLOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NPC_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/npc_pkg.sv
// ----------------------------------------------------------------------------
// npc_pkg
// Types, constants and reset palette for the nearest palette color block.
// ----------------------------------------------------------------------------
`default_nettype none

package npc_pkg;

    localparam int NPC_CHAN_W           = 8;
    localparam int NPC_INDEX_W          = 8;
    localparam int NPC_DIST_W           = 18;
    localparam int NPC_SQ_W             = 2 * NPC_CHAN_W;
    localparam int NPC_WRITABLE_ENTRIES = 256;

    // Above every reachable distance, so the first entry always takes the lead
    localparam logic [NPC_DIST_W-1:0] NPC_SEED_DISTANCE = NPC_DIST_W'(442 * 442);

    localparam logic NPC_ACT_WRITE = 1'b0;
    localparam logic NPC_ACT_QUERY = 1'b1;

    typedef struct packed {
        logic [NPC_CHAN_W-1:0] red;
        logic [NPC_CHAN_W-1:0] green;
        logic [NPC_CHAN_W-1:0] blue;
    } npc_rgb_t;

    typedef struct packed {
        logic                   action;
        logic [NPC_INDEX_W-1:0] entry_index;
        logic [NPC_CHAN_W-1:0]  red;
        logic [NPC_CHAN_W-1:0]  green;
        logic [NPC_CHAN_W-1:0]  blue;
    } npc_req_t;

    typedef struct packed {
        logic [NPC_INDEX_W-1:0] nearest_index;
        logic [NPC_DIST_W-1:0]  min_distance;
    } npc_rsp_t;

    // Control fanned out to every cell of the ring
    typedef struct packed {
        logic                   rotate;
        logic                   wr_en;
        logic [NPC_INDEX_W-1:0] wr_index;
        npc_rgb_t               wr_data;
    } npc_cell_ctrl_t;

    // Scan control toward the distance unit
    typedef struct packed {
        logic                   start;
        logic                   valid;
        logic                   last;
        logic [NPC_INDEX_W-1:0] index;
    } npc_scan_t;

    // Running best match from the distance unit
    typedef struct packed {
        logic                   done;
        logic [NPC_INDEX_W-1:0] index;
        logic [NPC_DIST_W-1:0]  distance;
    } npc_best_t;

    localparam logic [23:0] NPC_BASIC_COLORS [16] = '{
        24'h000000, 24'h800000, 24'h008000, 24'h808000,
        24'h000080, 24'h800080, 24'h008080, 24'hC0C0C0,
        24'h808080, 24'hFF0000, 24'h00FF00, 24'hFFFF00,
        24'h0000FF, 24'hFF00FF, 24'h00FFFF, 24'hFFFFFF
    };

    localparam logic [7:0] NPC_CUBE_LEVELS [6] = '{
        8'd0, 8'd95, 8'd135, 8'd175, 8'd215, 8'd255
    };

    localparam logic [7:0] NPC_GRAY_LEVELS [16] = '{
        8'd8,  8'd18,  8'd28,  8'd38,  8'd48,  8'd58,  8'd68,  8'd78,
        8'd88, 8'd96,  8'd102, 8'd118, 8'd128, 8'd138, 8'd148, 8'd158
    };

    // Power-up value of one palette entry; evaluated at elaboration only
    function automatic npc_rgb_t npc_reset_entry(input int unsigned idx);
        npc_rgb_t    rgb;
        int unsigned c;
        int unsigned ri;
        int unsigned gi;
        rgb = '0;
        c   = 0;
        ri  = 0;
        gi  = 0;
        if (idx < 16)
        begin
            rgb = NPC_BASIC_COLORS[idx];
        end
        else if (idx < 232)
        begin
            c = idx - 16;
            for (int k = 0; k < 6; k++)
            begin
                if (c >= 36)
                begin
                    c  = c - 36;
                    ri = ri + 1;
                end
            end
            for (int k = 0; k < 6; k++)
            begin
                if (c >= 6)
                begin
                    c  = c - 6;
                    gi = gi + 1;
                end
            end
            rgb.red   = NPC_CUBE_LEVELS[ri];
            rgb.green = NPC_CUBE_LEVELS[gi];
            rgb.blue  = NPC_CUBE_LEVELS[c];
        end
        else if (idx < 248)
        begin
            rgb.red   = NPC_GRAY_LEVELS[idx - 232];
            rgb.green = NPC_GRAY_LEVELS[idx - 232];
            rgb.blue  = NPC_GRAY_LEVELS[idx - 232];
        end
        return rgb;
    endfunction

endpackage

`default_nettype wire

// File: hdl/npc_stream_if.sv
// ----------------------------------------------------------------------------
// npc_stream_if
// Valid/ready channel carrying one payload of a chosen type.
// ----------------------------------------------------------------------------
`default_nettype none

interface npc_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/npc_cell.sv
// ----------------------------------------------------------------------------
// npc_cell
// One palette entry of the ring; loads from its neighbor or from a write.
// ----------------------------------------------------------------------------
`default_nettype none

module npc_cell #(
    parameter int INDEX = 0
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire npc_pkg::npc_cell_ctrl_t ctrl,
    input  wire npc_pkg::npc_rgb_t       shift_in,
    output npc_pkg::npc_rgb_t            entry
);
    import npc_pkg::*;

    localparam npc_rgb_t RESET_VALUE = npc_reset_entry(INDEX);
    localparam logic     WRITABLE    = (INDEX < NPC_WRITABLE_ENTRIES);

    npc_rgb_t entry_reg;
    npc_rgb_t entry_next;
    logic     hit;

    assign hit = WRITABLE && (ctrl.wr_index == NPC_INDEX_W'(INDEX));

    always_comb
    begin
        entry_next = entry_reg;
        priority if (ctrl.rotate)
        begin
            entry_next = shift_in;
        end
        else if (ctrl.wr_en && hit)
        begin
            entry_next = ctrl.wr_data;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= RESET_VALUE;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

// File: hdl/npc_dist.sv
// ----------------------------------------------------------------------------
// npc_dist
// Squared distance of the head entry to the pixel, and the running minimum.
// ----------------------------------------------------------------------------
`default_nettype none

module npc_dist (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire npc_pkg::npc_scan_t  scan,
    input  wire npc_pkg::npc_rgb_t   pixel,
    input  wire npc_pkg::npc_rgb_t   entry,
    output npc_pkg::npc_best_t       best
);
    import npc_pkg::*;

    function automatic logic [NPC_SQ_W-1:0] sq_diff(
        input logic [NPC_CHAN_W-1:0] a,
        input logic [NPC_CHAN_W-1:0] b
    );
        logic [NPC_CHAN_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return NPC_SQ_W'(d) * NPC_SQ_W'(d);
    endfunction

    // stage 1: per-channel squares
    logic                   s1_valid_reg;
    logic                   s1_last_reg;
    logic [NPC_INDEX_W-1:0] s1_index_reg;
    logic [NPC_SQ_W-1:0]    s1_sq_r_reg;
    logic [NPC_SQ_W-1:0]    s1_sq_g_reg;
    logic [NPC_SQ_W-1:0]    s1_sq_b_reg;

    // stage 2: sum, compare, running best
    logic                   done_reg;
    logic                   done_next;
    logic [NPC_INDEX_W-1:0] best_idx_reg;
    logic [NPC_INDEX_W-1:0] best_idx_next;
    logic [NPC_DIST_W-1:0]  best_dist_reg;
    logic [NPC_DIST_W-1:0]  best_dist_next;
    logic [NPC_DIST_W-1:0]  sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= scan.valid;
            s1_last_reg  <= scan.valid && scan.last;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_index_reg <= scan.index;
        s1_sq_r_reg  <= sq_diff(pixel.red,   entry.red);
        s1_sq_g_reg  <= sq_diff(pixel.green, entry.green);
        s1_sq_b_reg  <= sq_diff(pixel.blue,  entry.blue);
    end

    assign sum = NPC_DIST_W'(s1_sq_r_reg) + NPC_DIST_W'(s1_sq_g_reg)
               + NPC_DIST_W'(s1_sq_b_reg);

    always_comb
    begin
        done_next      = done_reg;
        best_idx_next  = best_idx_reg;
        best_dist_next = best_dist_reg;
        priority if (scan.start)
        begin
            done_next      = 1'b0;
            best_idx_next  = '0;
            best_dist_next = NPC_SEED_DISTANCE;
        end
        else if (s1_valid_reg)
        begin
            // strict compare: the lowest index keeps a tie
            if (sum < best_dist_reg)
            begin
                best_idx_next  = s1_index_reg;
                best_dist_next = sum;
            end
            if (s1_last_reg)
            begin
                done_next = 1'b1;
            end
        end
        else
        begin
            done_next = done_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_idx_reg  <= best_idx_next;
        best_dist_reg <= best_dist_next;
    end

    assign best.done     = done_reg;
    assign best.index    = best_idx_reg;
    assign best.distance = best_dist_reg;

endmodule

`default_nettype wire

// File: hdl/nearest_palette_color.sv
// ----------------------------------------------------------------------------
// nearest_palette_color
// Nearest-entry color quantizer over a palette held in a rotating cell ring.
// ----------------------------------------------------------------------------
//
//   channel  dir  payload                                      transaction
//   -------  ---  -------------------------------------------  --------------
//   req      in   action, entry_index, red, green, blue        write or query
//   rsp      out  nearest_index, min_distance                  one per query
//
// A write transaction is accepted back to back.
// A query occupies the block until its result is registered: the palette ring
// rotates once past the distance unit, one entry per cycle, and two
// pipeline stages follow. Reset loads every cell with its power-up color,
// so the block is ready as soon as reset is released. A stalled result
// waits in the output register; a new transaction is still accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_palette_color #(
    parameter int PALETTE_SIZE = 256
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    npc_stream_if.sink   req,
    npc_stream_if.source rsp
);
    import npc_pkg::*;

    localparam int CNT_W = $clog2(PALETTE_SIZE);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    npc_rgb_t         pixel_reg;
    npc_rgb_t         pixel_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    npc_rsp_t         out_data_reg;
    npc_rsp_t         out_data_next;

    logic             req_fire;
    logic             scan_last;
    npc_cell_ctrl_t   cell_ctrl;
    npc_scan_t        scan;
    npc_best_t        best;
    npc_rgb_t         cell_q [PALETTE_SIZE];

    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign scan_last = (cnt_reg == CNT_W'(PALETTE_SIZE - 1));

    // Write a single cell while idle; rotate the whole ring during a scan
    assign cell_ctrl.rotate        = (state_reg == ST_SCAN);
    assign cell_ctrl.wr_en         = req_fire && (req.data.action == NPC_ACT_WRITE);
    assign cell_ctrl.wr_index      = req.data.entry_index;
    assign cell_ctrl.wr_data.red   = req.data.red;
    assign cell_ctrl.wr_data.green = req.data.green;
    assign cell_ctrl.wr_data.blue  = req.data.blue;

    // Cell 0 is the head; after PALETTE_SIZE shifts the ring is home again
    for (genvar i = 0; i < PALETTE_SIZE; i++)
    begin : g_ring
        npc_cell #(
            .INDEX (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (cell_ctrl),
            .shift_in (cell_q[(i + 1) % PALETTE_SIZE]),
            .entry    (cell_q[i])
        );
    end

    // Scan control: start on an accepted query; index is the scan count in NPC_INDEX_W bits
    assign scan.start = req_fire && (req.data.action == NPC_ACT_QUERY);
    assign scan.valid = (state_reg == ST_SCAN);
    assign scan.last  = scan_last;
    assign scan.index = NPC_INDEX_W'(cnt_reg);

    npc_dist u_dist (
        .clk   (clk),
        .rst_n (rst_n),
        .scan  (scan),
        .pixel (pixel_reg),
        .entry (cell_q[0]),
        .best  (best)
    );

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pixel_next     = pixel_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        // drop the result once the sink takes it
        if (rsp.valid && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (scan.start)
                begin
                    pixel_next.red   = req.data.red;
                    pixel_next.green = req.data.green;
                    pixel_next.blue  = req.data.blue;
                    cnt_next         = '0;
                    state_next       = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (scan_last)
                begin
                    cnt_next   = '0;
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                // hold until the pipeline drains and the output slot is free
                if (best.done && (!out_valid_reg || rsp.ready))
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.nearest_index = best.index;
                    out_data_next.min_distance  = best.distance;
                    state_next                  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pixel_reg    <= pixel_next;
        out_data_reg <= out_data_next;
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

endmodule

`default_nettype wire

// File: hdl/npc_checker.sv
// ----------------------------------------------------------------------------
// npc_checker
// Port-level checks of the nearest palette color block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "nearest_palette_color_assert.svh"

module npc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        req_valid,
    input wire logic        req_ready,
    input wire logic        req_action,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire logic [25:0] rsp_payload
);
    import npc_pkg::*;

    logic write_fire;
    logic query_fire;

    assign write_fire = req_valid && req_ready && (req_action == NPC_ACT_WRITE);
    assign query_fire = req_valid && req_ready && (req_action == NPC_ACT_QUERY);

    `NPC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")

    `NPC_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_payload), "stalled result changed")

    `NPC_ASSERT_NEXT(a_write_silent, write_fire && !rsp_valid, !rsp_valid, "write produced a result")

    `NPC_ASSERT_NEXT(a_query_busy, query_fire, !req_ready, "ready during palette scan")

endmodule

bind nearest_palette_color npc_checker u_npc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .req_action  (req.data.action),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_payload (rsp.data)
);

`default_nettype wire

// File: test/tb_nearest_palette_color.sv
// ----------------------------------------------------------------------------
// tb_nearest_palette_color
// Self-checking bench for the nearest palette color block: drives write and
// query transactions over the request channel, keeps a shadow copy of the
// palette to predict each nearest match, and checks every response in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_nearest_palette_color;

    import npc_pkg::*;

    localparam int CLK_HALF        = 10;
    localparam int RESET_CYCLES    = 12;
    localparam int ENTRIES         = 256;
    // One query walks the whole ring plus two pipeline stages
    localparam int SCAN_CYCLES     = ENTRIES + 3;
    // Starting distance of a scan: above anything two colors can produce
    localparam int unsigned FAR_DISTANCE = 442 * 442;
    localparam int HOLD_OFF_CYCLES = 1500;
    // Cycles without any transaction on either channel before giving up
    localparam int STALL_LIMIT     = 6000;
    localparam int RANDOM_ITEMS    = 460;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #(CLK_HALF) clk = ~clk;

    npc_stream_if #(.T(npc_req_t)) req_if ();
    npc_stream_if #(.T(npc_rsp_t)) rsp_if ();

    nearest_palette_color #(
        .PALETTE_SIZE (ENTRIES)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // Shadow palette and the matches still owed by the block, oldest first
    npc_rgb_t shadow_palette [ENTRIES];
    npc_rsp_t owed_matches [$];

    int errors        = 0;
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    // Bumped by a test to ask the response side for one long hold-off
    int hold_requests = 0;
    int quiet_cycles  = 0;

    // ------------------------------------------------------------------------
    // Color helpers
    // ------------------------------------------------------------------------

    function automatic npc_rgb_t make_rgb(input int r, input int g, input int b);
        npc_rgb_t c;
        c.red   = r[7:0];
        c.green = g[7:0];
        c.blue  = b[7:0];
        return c;
    endfunction

    function automatic npc_rgb_t random_rgb();
        return make_rgb($urandom_range(255), $urandom_range(255), $urandom_range(255));
    endfunction

    // Move one channel a few steps either way, clamped to the channel range
    function automatic logic [7:0] nudge(input logic [7:0] v);
        int n;
        n = int'(v) + $urandom_range(6) - 3;
        if (n < 0)
        begin
            n = 0;
        end
        else if (n > 255)
        begin
            n = 255;
        end
        return n[7:0];
    endfunction

    // Power-up palette: basic colors, then the 6x6x6 cube, then the gray
    // ramp; the tail of the table stays black.
    function automatic npc_rgb_t power_up_color(input int idx);
        npc_rgb_t c;
        int       k;
        c = '0;
        k = idx - 16;
        if (idx < 16)
        begin
            c = NPC_BASIC_COLORS[idx];
        end
        else if (idx < 232)
        begin
            c.red   = NPC_CUBE_LEVELS[k / 36];
            c.green = NPC_CUBE_LEVELS[(k / 6) % 6];
            c.blue  = NPC_CUBE_LEVELS[k % 6];
        end
        else if (idx < 248)
        begin
            c.red   = NPC_GRAY_LEVELS[idx - 232];
            c.green = NPC_GRAY_LEVELS[idx - 232];
            c.blue  = NPC_GRAY_LEVELS[idx - 232];
        end
        return c;
    endfunction

    function automatic int unsigned channel_gap_sq(input logic [7:0] a, input logic [7:0] b);
        int d;
        d = int'(a) - int'(b);
        return d * d;
    endfunction

    // Scan the shadow palette in index order; a strict compare keeps the
    // lowest index on a tie.
    function automatic npc_rsp_t nearest_match(input npc_rgb_t px);
        npc_rsp_t    best;
        int unsigned gap_total;
        int unsigned best_dist;
        best      = '0;
        best_dist = FAR_DISTANCE;
        for (int i = 0; i < ENTRIES; i++)
        begin
            gap_total = channel_gap_sq(px.red,   shadow_palette[i].red)
                      + channel_gap_sq(px.green, shadow_palette[i].green)
                      + channel_gap_sq(px.blue,  shadow_palette[i].blue);
            if (gap_total < best_dist)
            begin
                best_dist          = gap_total;
                best.nearest_index = i[NPC_INDEX_W-1:0];
            end
        end
        best.min_distance = best_dist[NPC_DIST_W-1:0];
        return best;
    endfunction

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    // Drive one transaction from a falling edge, hold it until accepted, then
    // update the shadow palette or queue the match it must produce. Returns
    // at a falling edge, with valid still high unless an idle gap was drawn.
    task automatic send_request(input logic act, input logic [7:0] idx, input npc_rgb_t px);
        npc_req_t item;
        item.action      = act;
        item.entry_index = idx;
        item.red         = px.red;
        item.green       = px.green;
        item.blue        = px.blue;
        req_if.valid = 1'b1;
        req_if.data  = item;
        do
            @(posedge clk);
        while (!req_if.ready);
        if (act == NPC_ACT_WRITE)
        begin
            shadow_palette[idx] = px;
        end
        else
        begin
            owed_matches.push_back(nearest_match(px));
        end
        @(negedge clk);
        if ($urandom_range(99) < src_idle_pct)
        begin
            req_if.valid = 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < src_idle_pct);
        end
    endtask

    task automatic write_entry(input logic [7:0] idx, input npc_rgb_t px);
        send_request(NPC_ACT_WRITE, idx, px);
    endtask

    // The index field means nothing on a query, so fill it with noise
    task automatic query_color(input npc_rgb_t px);
        send_request(NPC_ACT_QUERY, 8'($urandom_range(255)), px);
    endtask

    // Drop valid and wait until every owed match has come back
    task automatic wait_drained();
        req_if.valid = 1'b0;
        while (owed_matches.size() != 0)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Response side: random ready, plus a long hold-off on request
    // ------------------------------------------------------------------------

    initial
    begin : response_side
        int hold_left;
        int hold_seen;
        hold_left    = 0;
        hold_seen    = 0;
        rsp_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_seen != hold_requests)
            begin
                hold_seen = hold_requests;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_if.ready = 1'b0;
            end
            else
            begin
                rsp_if.ready = ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // Compare each accepted response with the oldest owed match
    always @(posedge clk)
    begin : response_check
        npc_rsp_t want;
        npc_rsp_t got;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            got = rsp_if.data;
            if (owed_matches.size() == 0)
            begin
                $display("%0t: response with no query outstanding: index %0d distance %0d",
                         $time, got.nearest_index, got.min_distance);
                errors++;
            end
            else
            begin
                want = owed_matches.pop_front();
                if (got.nearest_index !== want.nearest_index)
                begin
                    $display("%0t: nearest_index expected %0d actual %0d",
                             $time, want.nearest_index, got.nearest_index);
                    errors++;
                end
                if (got.min_distance !== want.min_distance)
                begin
                    $display("%0t: min_distance expected %0d actual %0d",
                             $time, want.min_distance, got.min_distance);
                    errors++;
                end
            end
        end
    end

    // Watchdog: any transaction on either channel restarts the count
    always @(posedge clk)
    begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("simulation failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Query the untouched power-up palette: exact hits, ties between the
    // basic colors and the cube or gray ramp, and the channel extremes.
    task automatic test_power_up_palette();
        query_color(make_rgb(8'h00, 8'h00, 8'h00));    // black at 0 and 16: 0 wins
        query_color(make_rgb(8'hFF, 8'hFF, 8'hFF));    // white at 15 and 231
        query_color(make_rgb(8'hFF, 8'h00, 8'h00));
        query_color(make_rgb(8'h00, 8'hFF, 8'h00));
        query_color(make_rgb(8'h00, 8'h00, 8'hFF));
        query_color(make_rgb(8'h80, 8'h80, 8'h80));    // basic gray against ramp 128
        query_color(make_rgb(8'hC0, 8'hC0, 8'hC0));
        query_color(make_rgb(8'd8, 8'd8, 8'd8));       // first gray of the ramp
        query_color(make_rgb(8'd158, 8'd158, 8'd158)); // last gray of the ramp
        query_color(make_rgb(8'd1, 8'd1, 8'd1));
        query_color(make_rgb(8'd95, 8'd135, 8'd95));   // inside the cube
        query_color(make_rgb(8'h7F, 8'h7F, 8'h7F));
        wait_drained();
    endtask

    // Overwrite entries at both ends of the index range and check that
    // queries follow the new colors; duplicates must resolve to the lower index.
    task automatic test_entry_writes();
        write_entry(8'hFF, make_rgb(8'h12, 8'h34, 8'h56));
        query_color(make_rgb(8'h12, 8'h34, 8'h56));
        write_entry(8'h00, make_rgb(8'h0A, 8'h0B, 8'h0C));
        write_entry(8'hAA, make_rgb(8'h0A, 8'h0B, 8'h0C));
        query_color(make_rgb(8'h0A, 8'h0B, 8'h0C));
        write_entry(8'h55, make_rgb(8'h33, 8'h99, 8'hCC));
        write_entry(8'hAA, make_rgb(8'h33, 8'h99, 8'hCC));
        query_color(make_rgb(8'h34, 8'h98, 8'hCD));
        write_entry(8'h00, make_rgb(8'hFF, 8'hFF, 8'hFF));
        query_color(make_rgb(8'hFE, 8'hFF, 8'hFF));
        query_color(make_rgb(8'h00, 8'h00, 8'h00));
        wait_drained();
    endtask

    // Black out the whole palette so a white query hits the largest distance:
    // the first entry must still take the lead from the starting distance.
    task automatic test_largest_distance();
        for (int i = 0; i < ENTRIES; i++)
        begin
            write_entry(i[7:0], make_rgb(0, 0, 0));
        end
        query_color(make_rgb(8'hFF, 8'hFF, 8'hFF));
        query_color(make_rgb(8'h00, 8'h00, 8'h00));
        write_entry(8'hFF, make_rgb(8'hFF, 8'hFF, 8'hFF));
        query_color(make_rgb(8'hFF, 8'hFF, 8'hFF));
        query_color(make_rgb(8'h80, 8'h80, 8'h80));
        wait_drained();
    endtask

    // Hold the response side off for a long stretch while queries keep
    // coming, so the output register fills and the request side stalls.
    task automatic test_back_pressure();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        hold_requests++;
        @(negedge clk);
        repeat (6)
        begin
            query_color(random_rgb());
        end
        wait_drained();
    endtask

    // Random mix: writes that often duplicate a live color, and queries that
    // hit an entry exactly, land close to one, or fall anywhere.
    task automatic test_random_traffic(input int count, input int src_pct, input int sink_pct);
        int       roll;
        npc_rgb_t px;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        repeat (count)
        begin
            roll = $urandom_range(99);
            px   = shadow_palette[$urandom_range(ENTRIES - 1)];
            if (roll < 50)
            begin
                if ($urandom_range(3) != 0)
                begin
                    px = random_rgb();
                end
                write_entry(8'($urandom_range(255)), px);
            end
            else
            begin
                if (roll >= 80)
                begin
                    px = random_rgb();
                end
                else if (roll >= 65)
                begin
                    px.red   = nudge(px.red);
                    px.green = nudge(px.green);
                    px.blue  = nudge(px.blue);
                end
                query_color(px);
            end
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial
    begin
        req_if.valid = 1'b0;
        req_if.data  = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            shadow_palette[i] = power_up_color(i);
        end
        repeat (RESET_CYCLES)
        begin
            @(negedge clk);
        end
        rst_n = 1'b1;
        @(negedge clk);

        src_idle_pct  = 33;
        sink_idle_pct = 50;
        test_power_up_palette();
        test_entry_writes();
        test_largest_distance();
        test_back_pressure();
        test_random_traffic(RANDOM_ITEMS, 33, 50);
        test_random_traffic(RANDOM_ITEMS, 50, 33);
        test_random_traffic(RANDOM_ITEMS, 0, 0);

        // Give a stray response time to show up before judging the run
        wait_drained();
        repeat (SCAN_CYCLES + 16)
        begin
            @(posedge clk);
        end
        if (errors == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
